/* hdl/gapf_pkg.sv */
// ----------------------------------------------------------------------------
// gapf_pkg
// Shared types, constants and direction tables of the grid path finder.
// ----------------------------------------------------------------------------
package gapf_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int XW     = $clog2(MAX_WIDTH);
  localparam int YW     = $clog2(MAX_HEIGHT);
  localparam int CELL_W = XW + YW;
  localparam int NCELLS = 1 << CELL_W;
  localparam int LEN_W  = CELL_W + 1;
  localparam int COST_W = 16;
  localparam int SX_W   = XW + 2;
  localparam int SY_W   = YW + 2;

  localparam logic [COST_W-1:0] STEP_STRAIGHT = COST_W'(10);
  localparam logic [COST_W-1:0] STEP_DIAG     = COST_W'(14);

  typedef enum logic [1:0] {
    ACT_SET  = 2'd0,
    ACT_FIND = 2'd1,
    ACT_READ = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_SAME    = 3'd1,
    ST_OUTSIDE = 3'd2,
    ST_WALL    = 3'd3,
    ST_UNREACH = 3'd4,
    ST_BEYOND  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    MARK_NONE   = 2'd0,
    MARK_OPEN   = 2'd1,
    MARK_CLOSED = 2'd2
  } mark_t;

  typedef struct packed {
    logic              walk;
    logic [CELL_W-1:0] path_cell;
  } walk_entry_t;

  typedef struct packed {
    mark_t             mark;
    logic [COST_W-1:0] cost;
    logic [2:0]        parent;
  } srch_entry_t;

  // two's complement step of each direction, N NE E SE S SW W NW
  function automatic logic [1:0] dir_dx(input logic [2:0] d);
    logic [1:0] r;
    case (d)
      3'd1, 3'd2, 3'd3: r = 2'b01;
      3'd5, 3'd6, 3'd7: r = 2'b11;
      default:          r = 2'b00;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] dir_dy(input logic [2:0] d);
    logic [1:0] r;
    case (d)
      3'd0, 3'd1, 3'd7: r = 2'b11;
      3'd3, 3'd4, 3'd5: r = 2'b01;
      default:          r = 2'b00;
    endcase
    return r;
  endfunction

endpackage

/* hdl/grid_astar_path_finder_unit.sv */
// ----------------------------------------------------------------------------
// grid_astar_path_finder_unit
// A* search over an 8-connected walkability grid, path kept and read back.
//
//   channel   signals                          transaction
//   in        in_valid / in_ready              one command
//   out       out_valid / out_ready            one result
//   cfg       cfg_we, cfg_index, cfg_data      one register write
//
// set: read then write of the cell; read: read of the path memory, then output;
//   an unused action, a set outside the map or a read beyond the path go to done
// find: endpoint checks, a clear of every mark in the search memory, then per
//   expansion a full scan of the search memory for the least f, a pick, and
//   a read and an update per neighbor in the map, a skip per one outside it,
//   and a read and a write per path point for the walk back
// after reset a pass sets every cell walkable, in_ready stays low
// a result that is not taken holds the next one back in the done state
// ----------------------------------------------------------------------------
module grid_astar_path_finder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [5:0]  cell_x,
  input  logic [5:0]  cell_y,
  input  logic        walkable,
  input  logic [5:0]  dest_x,
  input  logic [5:0]  dest_y,
  input  logic [11:0] step_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [12:0] path_length,
  output logic [5:0]  point_x,
  output logic [5:0]  point_y,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);
  import gapf_pkg::*;

  typedef enum logic [18:0] {
    S_INIT     = 19'h00001,
    S_IDLE     = 19'h00002,
    S_SET_RD   = 19'h00004,
    S_SET_WR   = 19'h00008,
    S_CHK_SRC  = 19'h00010,
    S_CHK_DST  = 19'h00020,
    S_CHK_END  = 19'h00040,
    S_CLR      = 19'h00080,
    S_SRC_WR   = 19'h00100,
    S_SCAN     = 19'h00200,
    S_SCAN_END = 19'h00400,
    S_PICK     = 19'h00800,
    S_NB       = 19'h01000,
    S_NB_UPD   = 19'h02000,
    S_WB_RD    = 19'h04000,
    S_WB_WR    = 19'h08000,
    S_RD_PATH  = 19'h10000,
    S_RD_OUT   = 19'h20000,
    S_DONE     = 19'h40000
  } state_t;

  state_t state;

  logic [6:0]  grid_width;
  logic [6:0]  grid_height;
  logic [6:0]  eff_w;
  logic [6:0]  eff_h;

  logic [XW-1:0]     cx;
  logic [YW-1:0]     cy;
  logic              wk;
  logic [XW-1:0]     tx;
  logic [YW-1:0]     ty;
  logic [CELL_W-1:0] idx;
  logic [LEN_W-1:0]  stored_len;

  logic [CELL_W-1:0] cnt;
  logic              pend;
  logic [CELL_W-1:0] pend_idx;
  logic              best_vld;
  logic [CELL_W-1:0] best_idx;
  logic [COST_W:0]   best_f;
  logic [COST_W-1:0] best_cost;
  logic [2:0]        best_par;
  logic [2:0]        dir;
  logic              src_walk;
  logic [CELL_W-1:0] wb_cur;
  logic [LEN_W-1:0]  wb_n;

  status_t     res_status;
  logic [XW-1:0] res_x;
  logic [YW-1:0] res_y;

  logic              we_a;
  logic [CELL_W-1:0] waddr_a;
  walk_entry_t       wdata_a;
  logic [CELL_W-1:0] raddr_a;
  logic [$bits(walk_entry_t)-1:0] rdata_a;
  logic              we_b;
  logic [CELL_W-1:0] waddr_b;
  srch_entry_t       wdata_b;
  logic [CELL_W-1:0] raddr_b;
  logic [$bits(srch_entry_t)-1:0] rdata_b;
  walk_entry_t       ent_a;
  srch_entry_t       ent_b;

  logic [CELL_W-1:0] src_idx;
  logic [CELL_W-1:0] dst_idx;
  logic              in_src_ok;
  logic              in_dst_ok;
  logic              accept;

  logic [XW-1:0]     sx;
  logic [YW-1:0]     sy;
  logic [XW-1:0]     adx;
  logic [YW-1:0]     ady;
  logic [COST_W:0]   scan_f;
  logic              take;

  logic [1:0]        ddx;
  logic [1:0]        ddy;
  logic [1:0]        pdx;
  logic [1:0]        pdy;
  logic [SX_W-1:0]   nx;
  logic [SY_W-1:0]   ny;
  logic              nb_ok;
  logic [CELL_W-1:0] nb_idx;
  logic [COST_W-1:0] g;
  logic              nb_upd;

  logic [SX_W-1:0]   px;
  logic [SY_W-1:0]   py;
  logic              wb_stop;
  logic [LEN_W-1:0]  rd_pos;

  gapf_ram #(.DATA_W($bits(walk_entry_t)), .ADDR_W(CELL_W)) u_walk_ram (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr_a),
    .wdata (wdata_a),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  gapf_ram #(.DATA_W($bits(srch_entry_t)), .ADDR_W(CELL_W)) u_srch_ram (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr_b),
    .wdata (wdata_b),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  assign ent_a = walk_entry_t'(rdata_a);
  assign ent_b = srch_entry_t'(rdata_b);

  assign eff_w = (grid_width == 7'd0) ? 7'd1 :
                 (grid_width > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : grid_width;
  assign eff_h = (grid_height == 7'd0) ? 7'd1 :
                 (grid_height > 7'(MAX_HEIGHT)) ? 7'(MAX_HEIGHT) : grid_height;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign in_src_ok = ({1'b0, cell_x} < eff_w) && ({1'b0, cell_y} < eff_h);
  assign in_dst_ok = ({1'b0, dest_x} < eff_w) && ({1'b0, dest_y} < eff_h);
  assign src_idx   = {cy, cx};
  assign dst_idx   = {ty, tx};

  // least-f scan
  assign sx     = pend_idx[XW-1:0];
  assign sy     = pend_idx[CELL_W-1:XW];
  assign adx    = (sx > tx) ? sx - tx : tx - sx;
  assign ady    = (sy > ty) ? sy - ty : ty - sy;
  assign scan_f = {1'b0, ent_b.cost} + (COST_W+1)'(adx) + (COST_W+1)'(ady);
  assign take   = pend && (ent_b.mark == MARK_OPEN) && (!best_vld || scan_f < best_f);

  // neighbor of the expanded cell
  assign ddx    = dir_dx(dir);
  assign ddy    = dir_dy(dir);
  assign nx     = {2'b00, best_idx[XW-1:0]} + {{XW{ddx[1]}}, ddx};
  assign ny     = {2'b00, best_idx[CELL_W-1:XW]} + {{YW{ddy[1]}}, ddy};
  assign nb_ok  = (nx < SX_W'(eff_w)) && (ny < SY_W'(eff_h));
  assign nb_idx = {ny[YW-1:0], nx[XW-1:0]};
  assign g      = best_cost + (dir[0] ? STEP_DIAG : STEP_STRAIGHT);
  assign nb_upd = ent_a.walk && (ent_b.mark != MARK_CLOSED) &&
                  ((ent_b.mark != MARK_OPEN) || (g < ent_b.cost));

  // parent of the walk-back cell
  assign pdx = dir_dx(ent_b.parent);
  assign pdy = dir_dy(ent_b.parent);
  assign px  = {2'b00, wb_cur[XW-1:0]} - {{XW{pdx[1]}}, pdx};
  assign py  = {2'b00, wb_cur[CELL_W-1:XW]} - {{YW{pdy[1]}}, pdy};
  assign wb_stop = (wb_cur == src_idx) || (px >= SX_W'(MAX_WIDTH)) ||
                   (py >= SY_W'(MAX_HEIGHT)) || (wb_n == LEN_W'(NCELLS - 1));

  assign rd_pos = stored_len - {1'b0, idx} - LEN_W'(1);

  always_comb begin
    we_a    = 1'b0;
    waddr_a = cnt;
    wdata_a = '{walk: 1'b1, path_cell: '0};
    raddr_a = src_idx;
    we_b    = 1'b0;
    waddr_b = cnt;
    wdata_b = '{mark: MARK_NONE, cost: '0, parent: '0};
    raddr_b = cnt;
    case (state)
      S_INIT: begin
        we_a = 1'b1;
      end
      S_SET_WR: begin
        we_a    = 1'b1;
        waddr_a = src_idx;
        wdata_a = '{walk: wk, path_cell: ent_a.path_cell};
      end
      S_CHK_DST: begin
        raddr_a = dst_idx;
      end
      S_CLR: begin
        we_b = 1'b1;
      end
      S_SRC_WR: begin
        we_b    = 1'b1;
        waddr_b = src_idx;
        wdata_b = '{mark: MARK_OPEN, cost: '0, parent: '0};
      end
      S_PICK: begin
        we_b    = best_vld;
        waddr_b = best_idx;
        wdata_b = '{mark: MARK_CLOSED, cost: best_cost, parent: best_par};
      end
      S_NB: begin
        raddr_a = nb_idx;
        raddr_b = nb_idx;
      end
      S_NB_UPD: begin
        we_b    = nb_upd;
        waddr_b = nb_idx;
        wdata_b = '{mark: MARK_OPEN, cost: g, parent: dir};
      end
      S_WB_RD: begin
        raddr_a = wb_n[CELL_W-1:0];
        raddr_b = wb_cur;
      end
      S_WB_WR: begin
        we_a    = 1'b1;
        waddr_a = wb_n[CELL_W-1:0];
        wdata_a = '{walk: ent_a.walk, path_cell: wb_cur};
      end
      S_RD_PATH: begin
        raddr_a = rd_pos[CELL_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_INIT;
      cnt         <= '0;
      pend        <= 1'b0;
      best_vld    <= 1'b0;
      stored_len  <= '0;
      out_valid   <= 1'b0;
      grid_width  <= 7'(MAX_WIDTH);
      grid_height <= 7'(MAX_HEIGHT);
    end else begin
      if (cfg_we) begin
        if (cfg_index) begin
          grid_height <= cfg_data;
        end else begin
          grid_width <= cfg_data;
        end
      end
      if ((state == S_DONE) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      pend     <= (state == S_SCAN);
      pend_idx <= cnt;
      if (take) begin
        best_vld  <= 1'b1;
        best_idx  <= pend_idx;
        best_f    <= scan_f;
        best_cost <= ent_b.cost;
        best_par  <= ent_b.parent;
      end

      case (state)
        S_INIT: begin
          cnt <= cnt + 1'b1;
          if (cnt == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            cx         <= cell_x;
            cy         <= cell_y;
            wk         <= walkable;
            tx         <= dest_x;
            ty         <= dest_y;
            idx        <= step_index;
            res_status <= ST_OK;
            res_x      <= '0;
            res_y      <= '0;
            case (action_t'(action))
              ACT_SET: begin
                if (in_src_ok) begin
                  state <= S_SET_RD;
                end else begin
                  res_status <= ST_OUTSIDE;
                  state      <= S_DONE;
                end
              end
              ACT_FIND: begin
                stored_len <= '0;
                if ((cell_x == dest_x) && (cell_y == dest_y)) begin
                  res_status <= ST_SAME;
                  state      <= S_DONE;
                end else if (!(in_src_ok && in_dst_ok)) begin
                  res_status <= ST_OUTSIDE;
                  state      <= S_DONE;
                end else begin
                  state <= S_CHK_SRC;
                end
              end
              ACT_READ: begin
                if ({1'b0, step_index} >= stored_len) begin
                  res_status <= ST_BEYOND;
                  state      <= S_DONE;
                end else begin
                  state <= S_RD_PATH;
                end
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_SET_RD: begin
          state <= S_SET_WR;
        end
        S_SET_WR: begin
          state <= S_DONE;
        end
        S_CHK_SRC: begin
          state <= S_CHK_DST;
        end
        S_CHK_DST: begin
          src_walk <= ent_a.walk;
          state    <= S_CHK_END;
        end
        S_CHK_END: begin
          if (!src_walk || !ent_a.walk) begin
            res_status <= ST_WALL;
            state      <= S_DONE;
          end else begin
            cnt   <= '0;
            state <= S_CLR;
          end
        end
        S_CLR: begin
          cnt <= cnt + 1'b1;
          if (cnt == '1) begin
            state <= S_SRC_WR;
          end
        end
        S_SRC_WR: begin
          cnt      <= '0;
          best_vld <= 1'b0;
          state    <= S_SCAN;
        end
        S_SCAN: begin
          cnt <= cnt + 1'b1;
          if (cnt == '1) begin
            state <= S_SCAN_END;
          end
        end
        S_SCAN_END: begin
          state <= S_PICK;
        end
        S_PICK: begin
          if (!best_vld) begin
            res_status <= ST_UNREACH;
            state      <= S_DONE;
          end else if (best_idx == dst_idx) begin
            wb_n   <= '0;
            wb_cur <= dst_idx;
            state  <= S_WB_RD;
          end else begin
            dir   <= '0;
            state <= S_NB;
          end
        end
        S_NB: begin
          if (nb_ok) begin
            state <= S_NB_UPD;
          end else if (dir == 3'd7) begin
            cnt      <= '0;
            best_vld <= 1'b0;
            state    <= S_SCAN;
          end else begin
            dir <= dir + 1'b1;
          end
        end
        S_NB_UPD: begin
          if (dir == 3'd7) begin
            cnt      <= '0;
            best_vld <= 1'b0;
            state    <= S_SCAN;
          end else begin
            dir   <= dir + 1'b1;
            state <= S_NB;
          end
        end
        S_WB_RD: begin
          state <= S_WB_WR;
        end
        S_WB_WR: begin
          wb_n   <= wb_n + 1'b1;
          wb_cur <= {py[YW-1:0], px[XW-1:0]};
          if (wb_stop) begin
            stored_len <= wb_n + 1'b1;
            state      <= S_DONE;
          end else begin
            state <= S_WB_RD;
          end
        end
        S_RD_PATH: begin
          state <= S_RD_OUT;
        end
        S_RD_OUT: begin
          res_x <= ent_a.path_cell[XW-1:0];
          res_y <= ent_a.path_cell[CELL_W-1:XW];
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            status      <= res_status;
            path_length <= stored_len;
            point_x     <= res_x;
            point_y     <= res_y;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* hdl/gapf_ram.sv */
// ----------------------------------------------------------------------------
// gapf_ram
// Simple dual port synchronous memory, one write and one registered read.
// ----------------------------------------------------------------------------
module gapf_ram #(
  parameter int DATA_W = 8,
  parameter int ADDR_W = 12
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [1 << ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/gapf_checker.sv */
// ----------------------------------------------------------------------------
// gapf_checker
// Port-level checks of the grid path finder, bound to the top level.
// ----------------------------------------------------------------------------
module gapf_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [12:0] path_length,
  input logic [5:0]  point_x,
  input logic [5:0]  point_y
);
  import gapf_pkg::*;

  // result held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(path_length))
    else $error("result changed while stalled");

  // one command at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("command taken while busy");

  a_beyond_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_BEYOND) |-> (point_x == '0) && (point_y == '0))
    else $error("point not zero beyond path");

  a_fail_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((status == ST_SAME) || (status == ST_WALL) || (status == ST_UNREACH))
    |-> (path_length == '0))
    else $error("failed search left a path");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind grid_astar_path_finder_unit gapf_checker u_gapf_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .status      (status),
  .path_length (path_length),
  .point_x     (point_x),
  .point_y     (point_y)
);

/* tb/grid_astar_path_finder_unit_test.sv */
// ----------------------------------------------------------------------------
// grid_astar_path_finder_unit_test
// Sends map edits, path searches and path reads to the path finder.
// Each result is checked against a built-in A* predictor that keeps its own
// map, search memory and stored path. Both handshakes stall at random.
// ----------------------------------------------------------------------------
module grid_astar_path_finder_unit_test;
  import gapf_pkg::*;

  localparam int GRID_CELLS = 4096;
  localparam int STALL_LIMIT = 300000;
  localparam int REG_WIDTH = 0;
  localparam int REG_HEIGHT = 1;

  typedef struct {
    status_t     st;
    logic [12:0] len;
    logic [5:0]  px;
    logic [5:0]  py;
  } answer_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_ready;
  logic [1:0]  action = 0;
  logic [5:0]  cell_x = 0;
  logic [5:0]  cell_y = 0;
  logic        walkable = 0;
  logic [5:0]  dest_x = 0;
  logic [5:0]  dest_y = 0;
  logic [11:0] step_index = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [2:0]  status;
  logic [12:0] path_length;
  logic [5:0]  point_x;
  logic [5:0]  point_y;
  logic        cfg_we = 0;
  logic        cfg_index = 0;
  logic [6:0]  cfg_data = 0;

  // predictor state
  bit        map_walk [GRID_CELLS];
  bit [1:0]  srch_mark [GRID_CELLS];
  int        srch_cost [GRID_CELLS];
  int        srch_dir [GRID_CELLS];
  int        route [GRID_CELLS];
  int        route_len;
  int        width_reg;
  int        height_reg;

  answer_t   expected_answers[$];
  int        failures = 0;
  bit        no_idle = 0;
  int        stall_count = 0;

  grid_astar_path_finder_unit DUT (.*);

  always #2 clk = ~clk;

  function automatic int eff_size(int r);
    if (r == 0) return 1;
    if (r > 64) return 64;
    return r;
  endfunction

  function automatic int step_dx(int d);
    if (d >= 1 && d <= 3) return 1;
    if (d >= 5) return -1;
    return 0;
  endfunction

  function automatic int step_dy(int d);
    if (d <= 1 || d == 7) return -1;
    if (d >= 3 && d <= 5) return 1;
    return 0;
  endfunction

  function automatic int abs_diff(int a, int b);
    return a > b ? a - b : b - a;
  endfunction

  function automatic status_t astar_search(int sx, int sy, int tx, int ty);
    int w, h, src, dst, cur, best, bestf, f, nx, ny, n, g, k, t;
    bit found;
    w = eff_size(width_reg);
    h = eff_size(height_reg);
    found = 0;
    route_len = 0;
    if (sx == tx && sy == ty) return ST_SAME;
    if (sx >= w || sy >= h || tx >= w || ty >= h) return ST_OUTSIDE;
    src = sy * 64 + sx;
    dst = ty * 64 + tx;
    if (!map_walk[src] || !map_walk[dst]) return ST_WALL;
    foreach (srch_mark[i]) srch_mark[i] = MARK_NONE;
    srch_mark[src] = MARK_OPEN;
    srch_cost[src] = 0;
    srch_dir[src] = 0;
    forever begin
      best = -1;
      bestf = 0;
      for (int i = 0; i < GRID_CELLS; i++) begin
        if (srch_mark[i] == MARK_OPEN) begin
          f = srch_cost[i] + abs_diff(i % 64, tx) + abs_diff(i / 64, ty);
          if (best < 0 || f < bestf) begin
            best = i;
            bestf = f;
          end
        end
      end
      if (best < 0) break;
      cur = best;
      srch_mark[cur] = MARK_CLOSED;
      if (cur == dst) begin
        found = 1;
        break;
      end
      for (int d = 0; d < 8; d++) begin
        nx = cur % 64 + step_dx(d);
        ny = cur / 64 + step_dy(d);
        if (nx < 0 || ny < 0 || nx >= w || ny >= h) continue;
        n = ny * 64 + nx;
        if (!map_walk[n] || srch_mark[n] == MARK_CLOSED) continue;
        g = (srch_cost[cur] + ((d % 2) ? 14 : 10)) & 16'hFFFF;
        if (srch_mark[n] == MARK_OPEN) begin
          if (g < srch_cost[n]) begin
            srch_cost[n] = g;
            srch_dir[n] = d;
          end
        end else begin
          srch_mark[n] = MARK_OPEN;
          srch_cost[n] = g;
          srch_dir[n] = d;
        end
      end
    end
    if (!found) return ST_UNREACH;
    n = 0;
    cur = dst;
    while (n < GRID_CELLS) begin
      route[n] = cur;
      n++;
      if (cur == src) break;
      nx = cur % 64 - step_dx(srch_dir[cur]);
      ny = cur / 64 - step_dy(srch_dir[cur]);
      if (nx < 0 || ny < 0 || nx >= 64 || ny >= 64) break;
      cur = ny * 64 + nx;
    end
    for (k = 0; k < n / 2; k++) begin
      t = route[k];
      route[k] = route[n - 1 - k];
      route[n - 1 - k] = t;
    end
    route_len = n;
    return ST_OK;
  endfunction

  function automatic void predict_command(action_t a, int x, int y, bit wk, int dx, int dy,
                                          int idx);
    answer_t ans;
    ans.st = ST_OK;
    ans.px = 0;
    ans.py = 0;
    case (a)
      ACT_SET: begin
        if (x >= eff_size(width_reg) || y >= eff_size(height_reg)) ans.st = ST_OUTSIDE;
        else map_walk[y * 64 + x] = wk;
      end
      ACT_FIND: ans.st = astar_search(x, y, dx, dy);
      ACT_READ: begin
        if (idx >= route_len) ans.st = ST_BEYOND;
        else begin
          ans.px = 6'(route[idx] % 64);
          ans.py = 6'(route[idx] / 64);
        end
      end
      default: ;
    endcase
    ans.len = 13'(route_len);
    expected_answers.push_back(ans);
  endfunction

  task automatic send_cmd(action_t a, int x, int y, bit wk, int dx, int dy, int idx);
    while (!no_idle && $urandom_range(99) < 6) begin
      @(negedge clk);
      in_valid = 0;
    end
    @(negedge clk);
    in_valid = 1;
    action = a;
    cell_x = 6'(x);
    cell_y = 6'(y);
    walkable = wk;
    dest_x = 6'(dx);
    dest_y = 6'(dy);
    step_index = 12'(idx);
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    predict_command(a, x, y, wk, dx, dy, idx);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid = 0;
    while (expected_answers.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(int index, int value);
    @(negedge clk);
    cfg_we = 1;
    cfg_index = 1'(index);
    cfg_data = 7'(value);
    @(negedge clk);
    cfg_we = 0;
    if (index == REG_WIDTH) width_reg = value & 7'h7F;
    else height_reg = value & 7'h7F;
  endtask

  task automatic set_cell(int x, int y, bit wk);
    send_cmd(ACT_SET, x, y, wk, $urandom_range(63), $urandom_range(63), $urandom_range(4095));
  endtask

  task automatic find_path(int sx, int sy, int tx, int ty);
    send_cmd(ACT_FIND, sx, sy, 1'($urandom_range(1)), tx, ty, $urandom_range(4095));
  endtask

  task automatic read_step(int idx);
    send_cmd(ACT_READ, $urandom_range(63), $urandom_range(63), 1'($urandom_range(1)),
             $urandom_range(63), $urandom_range(63), idx);
  endtask

  task automatic test_size_extremes();
    write_reg(REG_WIDTH, 0);
    write_reg(REG_HEIGHT, 127);
    set_cell(0, 63, 1);
    set_cell(1, 0, 0);
    find_path(0, 5, 0, 5);
    find_path(0, 0, 1, 0);
    drain_results();
    write_reg(REG_WIDTH, 64);
    write_reg(REG_HEIGHT, 1);
    find_path(0, 0, 5, 0);
    read_step(0);
    read_step(5);
    read_step(6);
    drain_results();
  endtask

  task automatic test_small_map();
    write_reg(REG_WIDTH, 4);
    write_reg(REG_HEIGHT, 4);
    set_cell(4, 0, 0);
    set_cell(1, 1, 0);
    set_cell(2, 1, 0);
    set_cell(1, 2, 0);
    find_path(0, 0, 3, 3);
    read_step(0);
    read_step(1);
    read_step(4095);
    send_cmd(ACT_NONE, 63, 63, 1, 63, 63, 4095);
    find_path(0, 0, 1, 1);
    find_path(0, 0, 63, 0);
    drain_results();
    write_reg(REG_WIDTH, 3);
    write_reg(REG_HEIGHT, 3);
    find_path(0, 0, 2, 2);
    read_step(0);
    drain_results();
  endtask

  task automatic test_random_traffic();
    int w, h, r;
    for (int i = 0; i < 80; i++) begin
      if (i == 0 || i == 40) begin
        drain_results();
        write_reg(REG_WIDTH, $urandom_range(4, 1));
        write_reg(REG_HEIGHT, $urandom_range(4, 1));
      end
      no_idle = (i >= 20 && i < 40);
      w = eff_size(width_reg);
      h = eff_size(height_reg);
      r = $urandom_range(99);
      if (r < 14) begin
        if (r < 2) find_path($urandom_range(63), $urandom_range(63), $urandom_range(63),
                             $urandom_range(63));
        else find_path($urandom_range(w - 1), $urandom_range(h - 1), $urandom_range(w - 1),
                       $urandom_range(h - 1));
      end else if (r < 50) begin
        if (r < 45) set_cell($urandom_range(w - 1), $urandom_range(h - 1),
                             $urandom_range(99) < 70);
        else set_cell($urandom_range(63), $urandom_range(63), 1'($urandom_range(1)));
      end else if (r < 94) begin
        if (r < 88) read_step($urandom_range(route_len));
        else read_step($urandom_range(4095));
      end else begin
        send_cmd(ACT_NONE, $urandom_range(63), $urandom_range(63), 1'($urandom_range(1)),
                 $urandom_range(63), $urandom_range(63), $urandom_range(4095));
      end
    end
    no_idle = 0;
    drain_results();
  endtask

  task automatic test_size_overflow();
    write_reg(REG_WIDTH, 127);
    write_reg(REG_HEIGHT, 0);
    set_cell(63, 0, 1);
    set_cell(0, 1, 1);
    find_path(63, 0, 63, 0);
    find_path(0, 0, 0, 1);
    read_step(0);
    drain_results();
  endtask

  always @(negedge clk) begin
    out_ready = no_idle || ($urandom_range(99) >= 6);
  end

  always @(posedge clk) begin
    answer_t exp_ans;
    if (!rst && out_valid && out_ready) begin
      if (expected_answers.size() == 0) begin
        $display("%0t: result with none pending: status %0d len %0d point %0d,%0d", $time,
                 status, path_length, point_x, point_y);
        failures++;
      end else begin
        exp_ans = expected_answers.pop_front();
        if (status !== exp_ans.st) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_ans.st, status);
          failures++;
        end
        if (path_length !== exp_ans.len) begin
          $display("%0t: path_length expected %0d actual %0d", $time, exp_ans.len,
                   path_length);
          failures++;
        end
        if (point_x !== exp_ans.px) begin
          $display("%0t: point_x expected %0d actual %0d", $time, exp_ans.px, point_x);
          failures++;
        end
        if (point_y !== exp_ans.py) begin
          $display("%0t: point_y expected %0d actual %0d", $time, exp_ans.py, point_y);
          failures++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_count <= 0;
    else stall_count <= stall_count + 1;
    if (stall_count >= STALL_LIMIT) begin
      $display("grid_astar_path_finder_unit_test NOT OK");
      $finish;
    end
  end

  initial begin
    foreach (map_walk[i]) map_walk[i] = 1;
    route_len = 0;
    width_reg = 64;
    height_reg = 64;
    repeat (2) @(negedge clk);
    rst = 0;
    test_size_extremes();
    test_small_map();
    test_random_traffic();
    test_size_overflow();
    if (expected_answers.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_answers.size());
      failures++;
    end
    if (failures == 0) $display("grid_astar_path_finder_unit_test OK");
    else $display("grid_astar_path_finder_unit_test NOT OK");
    $finish;
  end

endmodule
